// ===== hw/rtl/keyword_class_detector_assert.svh =====
// Assertion macros for the keyword class detector.
// Used by the front and back modules; no other dependencies.
`ifndef KEYWORD_CLASS_DETECTOR_ASSERT_SVH
`define KEYWORD_CLASS_DETECTOR_ASSERT_SVH
// Implication checked on every edge outside reset.
`define KCD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/kcd_pkg.sv =====
// Package for the keyword class detector: types, phrase table, constants.
// No dependencies.
`default_nettype none
package kcd_pkg;
    localparam int WINDOW_BYTES_DEF = 18;
    localparam int PHRASE_COUNT = 52;
    localparam int PHRASE_MAX = 17;
    localparam int SEEN_MAX = 31;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_NEGATOR = 2'd0,
        KIND_ACHIEVE = 2'd1,
        KIND_MILESTONE = 2'd2,
        KIND_UPBEAT = 2'd3
    } t_kind;

    localparam logic [1:0] WIN_NONE = 2'd0;
    localparam logic [1:0] WIN_ACHIEVE = 2'd1;
    localparam logic [1:0] WIN_MILESTONE = 2'd2;
    localparam logic [1:0] WIN_UPBEAT = 2'd3;
    localparam logic [6:0] CONF_ACHIEVE = 7'd85;
    localparam logic [6:0] CONF_MILESTONE = 7'd70;
    localparam logic [6:0] CONF_UPBEAT = 7'd75;

    // Classified message summary handed from front to back.
    typedef struct packed {
        logic negator;
        logic achieve;
        logic milestone;
        logic upbeat;
    } t_flags;

    typedef struct packed {
        logic       is_win;
        logic [1:0] win_kind;
        logic [6:0] confidence_pct;
    } t_result;

    typedef logic [PHRASE_MAX*8-1:0] t_text;

    // Phrase text, first character in the low byte.
    function automatic t_text phrase_text(input int idx);
        string s;
        t_text t;
        case (idx)
            0: s = "didn't"; 1: s = "did not"; 2: s = "not "; 3: s = "no longer";
            4: s = "couldn't"; 5: s = "could not"; 6: s = "failed"; 7: s = "won't";
            8: s = "wasn't"; 9: s = "isn't"; 10: s = "can't"; 11: s = "unfortunately";
            12: s = "rejected"; 13: s = "denied"; 14: s = "fell through"; 15: s = "lost";
            16: s = "cancelled"; 17: s = "canceled";
            18: s = "i did it"; 19: s = "i finished"; 20: s = "i shipped";
            21: s = "i passed"; 22: s = "i got the job"; 23: s = "i landed";
            24: s = "i nailed"; 25: s = "i completed"; 26: s = "i won";
            27: s = "we shipped"; 28: s = "we launched"; 29: s = "got promoted";
            30: s = "got accepted"; 31: s = "got in"; 32: s = "aced"; 33: s = "graduated";
            34: s = "anniversary"; 35: s = "first time"; 36: s = "years together";
            37: s = "years sober"; 38: s = "milestone"; 39: s = "100th"; 40: s = "1000th";
            41: s = "one year"; 42: s = "ten years"; 43: s = "big day";
            44: s = "great news"; 45: s = "good news"; 46: s = "excited to share";
            47: s = "guess what"; 48: s = "amazing news"; 49: s = "wonderful news";
            50: s = "so excited"; 51: s = "thrilled to share";
            default: s = "";
        endcase
        t = '0;
        for (int k = 0; k < PHRASE_MAX; k++) begin
            if (k < s.len()) t[k*8 +: 8] = s[k];
        end
        return t;
    endfunction

    function automatic int phrase_len(input int idx);
        t_text t;
        int n;
        t = phrase_text(idx);
        n = 0;
        for (int k = 0; k < PHRASE_MAX; k++) begin
            if (t[k*8 +: 8] != 8'd0) n = k + 1;
        end
        return n;
    endfunction

    function automatic t_kind phrase_kind(input int idx);
        if (idx < 18) return KIND_NEGATOR;
        else if (idx < 34) return KIND_ACHIEVE;
        else if (idx < 44) return KIND_MILESTONE;
        else return KIND_UPBEAT;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kcd_stream_if.sv =====
// Valid/ready stream interface, payload type given as parameter.
// Depends on nothing.
`default_nettype none
interface kcd_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kcd_front.sv =====
// Front part: byte window, phrase match and per-message flags.
// Depends on kcd_pkg and the assertion macro header.
`default_nettype none
`include "keyword_class_detector_assert.svh"
module kcd_front import kcd_pkg::*; #(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_message,
    output logic            o_ready,
    output logic            o_flag_valid,
    output t_flags          o_flags,
    input  wire logic       i_flag_ready
);
    logic [WINDOW_BYTES-1:0][7:0] r_window, n_window;
    logic [4:0] r_seen, n_seen;
    t_flags r_flags, n_flags, hit_prev, hit_last, msg_flags;
    logic accept;

    assign o_ready = i_flag_ready;
    assign accept = i_valid && o_ready;

    // Match every phrase ending at window entry 0 of the given window.
    function automatic t_flags scan(input logic [WINDOW_BYTES-1:0][7:0] w,
                                    input logic [4:0] seen);
        t_flags f;
        t_text t;
        int n;
        logic hit;
        logic left;
        f = '0;
        for (int i = 0; i < PHRASE_COUNT; i++) begin
            t = phrase_text(i);
            n = phrase_len(i);
            hit = (n <= int'(seen)) && (n <= WINDOW_BYTES);
            for (int k = 0; k < PHRASE_MAX; k++) begin
                if (k < n && k < WINDOW_BYTES)
                    if (to_lower(w[n-1-k]) != t[k*8 +: 8]) hit = 1'b0;
            end
            if (int'(seen) == n) left = 1'b1;
            else if (n < WINDOW_BYTES) left = !is_alnum(w[n]);
            else left = 1'b0;
            if (hit && left) begin
                unique case (phrase_kind(i))
                    KIND_NEGATOR:   f.negator = 1'b1;
                    KIND_ACHIEVE:   f.achieve = 1'b1;
                    KIND_MILESTONE: f.milestone = 1'b1;
                    KIND_UPBEAT:    f.upbeat = 1'b1;
                endcase
            end
        end
        return f;
    endfunction

    always_comb begin
        hit_prev = is_alnum(i_text_byte) ? t_flags'('0) : scan(r_window, r_seen);
        n_window = {r_window[WINDOW_BYTES-2:0], i_text_byte};
        n_seen = (r_seen < 5'(SEEN_MAX)) ? r_seen + 5'd1 : r_seen;
        hit_last = scan(n_window, n_seen);
        msg_flags = r_flags | hit_prev | hit_last;
        n_flags = r_flags | hit_prev;
        if (i_end_of_message) begin
            n_window = '0;
            n_seen = '0;
            n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen <= '0;
            r_flags <= '0;
        end else if (accept) begin
            r_window <= n_window;
            r_seen <= n_seen;
            r_flags <= n_flags;
        end
    end

    assign o_flag_valid = accept && i_end_of_message;
    assign o_flags = msg_flags;

    `KCD_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, accept && i_end_of_message, r_seen == 5'd0 && r_flags == '0)
    `KCD_ASSERT_NEXT(a_seen_grows, i_clk, i_rst_n, accept && !i_end_of_message && r_seen < 5'd31, r_seen == $past(r_seen) + 5'd1)
    `KCD_ASSERT_IMP(a_seen_zero_empty, i_clk, i_rst_n, r_seen == 5'd0, r_flags == '0)
endmodule
`default_nettype wire

// ===== hw/rtl/kcd_back.sv =====
// Back part: flag queue, priority resolve and output register.
// Depends on kcd_pkg and the assertion macro header.
`default_nettype none
`include "keyword_class_detector_assert.svh"
module kcd_back import kcd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_flag_valid,
    input  t_flags    i_flags,
    output logic      o_flag_ready,
    output logic      o_valid,
    output t_result   o_result,
    input  wire logic i_ready
);
    t_flags r_q [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic r_ov;
    t_result r_res, n_res;
    t_flags head;
    logic push, pop, load;

    assign o_flag_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign push = i_flag_valid && o_flag_ready;
    assign load = (!r_ov || i_ready);
    assign pop = (r_cnt != 2'd0) && load;
    assign head = r_q[r_rp];

    always_comb begin
        n_res = '0;
        if (!head.negator) begin
            if (head.achieve) n_res = '{1'b1, WIN_ACHIEVE, CONF_ACHIEVE};
            else if (head.milestone) n_res = '{1'b1, WIN_MILESTONE, CONF_MILESTONE};
            else if (head.upbeat) n_res = '{1'b1, WIN_UPBEAT, CONF_UPBEAT};
        end
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_flags;
        if (pop) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= n_cnt;
            if (load) r_ov <= pop;
        end
    end

    assign o_valid = r_ov;
    assign o_result = r_res;

    `KCD_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `KCD_ASSERT_IMP(a_win_consistent, i_clk, i_rst_n, r_ov, r_res.is_win == (r_res.win_kind != WIN_NONE))
    `KCD_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_res))
endmodule
`default_nettype wire

// ===== hw/rtl/keyword_class_detector.sv =====
// Channel   | Dir | Payload
// i_in      | in  | text_byte[7:0], end_of_message
// o_out     | out | is_win, win_kind[1:0], confidence_pct[6:0]
// One byte per cycle sustained while the flag queue has room; phrase match is done in the cycle a byte is taken.
// After its final byte is taken, a result passes through the queue entry, then the output register.
// Input stalls while the two-entry queue is full; that lasts through the cycle the output frees.
// Synchronous active-low reset clears window, counters, flags and queue.
// Top level of the keyword class detector; depends on kcd_pkg,
// kcd_stream_if, kcd_front and kcd_back.
`default_nettype none
module keyword_class_detector import kcd_pkg::*; #(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    kcd_stream_if.sink   i_in,
    kcd_stream_if.source o_out
);
    logic fv, fr;
    t_flags fl;
    t_result res;

    kcd_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid),
        .i_text_byte(i_in.data[8:1]),
        .i_end_of_message(i_in.data[0]),
        .o_ready(i_in.ready),
        .o_flag_valid(fv), .o_flags(fl), .i_flag_ready(fr)
    );

    kcd_back u_back (
        .i_clk, .i_rst_n,
        .i_flag_valid(fv), .i_flags(fl), .o_flag_ready(fr),
        .o_valid(o_out.valid), .o_result(res), .i_ready(o_out.ready)
    );

    assign o_out.data = res;
endmodule
`default_nettype wire
